// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ESC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("esc assertion failed");

// Next-cycle implication, gated off during reset.
`define ESC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("esc assertion failed");

`endif

// ===== hdl/esc_pkg.sv =====
package esc_pkg;

   localparam int SECS_W  = 32;
   localparam int DAYS_W  = 16;
   localparam int TOD_W   = 17;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int MDAY_W  = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int WDAY_W  = 3;
   localparam int OFF_W   = 8;
   localparam int DOY_W   = 9;
   localparam int LEAPS_W = 6;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_MIN  = 60;
   localparam int MINS_PER_HOUR = 60;
   localparam int DAYS_PER_YEAR = 365;
   localparam int DAYS_PER_WEEK = 7;
   localparam int EPOCH_YEAR    = 1970;
   localparam int EPOCH_WDAY    = 4;
   localparam int MONTHS        = 12;

   // seconds / 86400 = (seconds >> 7) / 675
   localparam int     DAY_SHIFT  = 7;
   localparam int     DAY_ODD    = SECS_PER_DAY >> DAY_SHIFT;
   localparam int     DAY_K      = 32;
   localparam longint DAY_RECIP  = (64'd1 << DAY_K) / DAY_ODD;
   localparam int     DAY_PROD_W = 48;
   localparam int     DAY_MUL_W  = 26;
   localparam int     DAY_REM_W  = 18;

   // days / 365 and (days + 4) / 7
   localparam int YEAR_RECIP = (1 << DAYS_W) / DAYS_PER_YEAR;
   localparam int YEAR_PROD_W = 24;
   localparam int WEEK_W      = DAYS_W + 1;
   localparam int WEEK_RECIP  = (1 << WEEK_W) / DAYS_PER_WEEK;
   localparam int WEEK_PROD_W = 30;

   // tod / 60 and minutes / 60
   localparam int MINS_W      = 11;
   localparam int MIN_RECIP   = (1 << TOD_W) / SECS_PER_MIN;
   localparam int MIN_PROD_W  = 28;
   localparam int HOUR_RECIP  = (1 << MINS_W) / MINS_PER_HOUR;
   localparam int HOUR_PROD_W = 16;

   // 2100 is the only non-leap multiple of 4 in range
   localparam logic [OFF_W-1:0] CENTURY_SKIP_OFF = OFF_W'(2100 - EPOCH_YEAR);

   localparam logic [DOY_W-1:0] CUM_DAYS [MONTHS] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   // year offset from 1970 is a leap year
   function automatic logic leap_of_off(input logic [OFF_W-1:0] off);
      return (off[1:0] == 2'd2) && (off != CENTURY_SKIP_OFF);
   endfunction

   // leap days in years 1970 .. 1970+off-1
   function automatic logic [LEAPS_W-1:0] leaps_before(input logic [OFF_W-1:0] off);
      logic [OFF_W:0] plus_one;
      logic [LEAPS_W-1:0] cnt;
      plus_one = {1'b0, off} + {{OFF_W{1'b0}}, 1'b1};
      cnt = LEAPS_W'(plus_one[OFF_W:2]);
      if (off > CENTURY_SKIP_OFF) begin
         cnt = cnt - LEAPS_W'(1);
      end
      return cnt;
   endfunction

   // days before the first of a month
   function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
      logic [DOY_W-1:0] base;
      base = '0;
      if (month < MONTH_W'(MONTHS)) begin
         base = CUM_DAYS[month];
      end
      if (month >= MONTH_W'(2)) begin
         base = base + DOY_W'(leap);
      end
      return base;
   endfunction

endpackage

// ===== hdl/esc_day_split.sv =====
`include "assert_macros.svh"

module esc_day_split (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [esc_pkg::SECS_W-1:0]  in_secs,
   output logic                        out_valid,
   output logic [esc_pkg::DAYS_W-1:0]  out_days,
   output logic [esc_pkg::TOD_W-1:0]   out_tod
);
   import esc_pkg::*;

   logic [2:0]            valid_ff, valid_in;
   logic [SECS_W-1:0]     secs1_ff, secs2_ff;
   logic [DAY_PROD_W-1:0] prod1_ff, prod1_in;
   logic [DAYS_W-1:0]     q2_ff, q2_in;
   logic [DAY_MUL_W-1:0]  mul2_ff, mul2_in;
   logic [DAYS_W-1:0]     days_ff, days_in;
   logic [TOD_W-1:0]      tod_ff, tod_in;
   logic [SECS_W-1:0]     diff;
   logic [DAY_REM_W-1:0]  rem;

   always_comb begin
      valid_in = {valid_ff[1:0], in_valid};
      prod1_in = DAY_PROD_W'(in_secs[SECS_W-1:DAY_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
      q2_in    = prod1_ff[DAY_PROD_W-1 -: DAYS_W];
      mul2_in  = DAY_MUL_W'(q2_in) * DAY_MUL_W'(DAY_ODD);
      diff     = secs2_ff - SECS_W'({mul2_ff, {DAY_SHIFT{1'b0}}});
      rem      = diff[DAY_REM_W-1:0];
      if (rem >= DAY_REM_W'(SECS_PER_DAY)) begin
         days_in = q2_ff + DAYS_W'(1);
         tod_in  = TOD_W'(rem - DAY_REM_W'(SECS_PER_DAY));
      end else begin
         days_in = q2_ff;
         tod_in  = TOD_W'(rem);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      secs1_ff <= in_secs;
      prod1_ff <= prod1_in;
      secs2_ff <= secs1_ff;
      q2_ff    <= q2_in;
      mul2_ff  <= mul2_in;
      days_ff  <= days_in;
      tod_ff   <= tod_in;
   end

   assign out_valid = valid_ff[2];
   assign out_days  = days_ff;
   assign out_tod   = tod_ff;

   `ESC_ASSERT_IMPLY(tod_in_day_a, clock, reset, valid_ff[2], tod_ff < TOD_W'(SECS_PER_DAY))

endmodule

// ===== hdl/esc_clock.sv =====
`include "assert_macros.svh"

module esc_clock (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [esc_pkg::TOD_W-1:0]  in_tod,
   output logic                       out_valid,
   output logic [esc_pkg::HOUR_W-1:0] out_hour,
   output logic [esc_pkg::MIN_W-1:0]  out_minute,
   output logic [esc_pkg::SEC_W-1:0]  out_second
);
   import esc_pkg::*;

   logic [6:0]             valid_ff, valid_in;
   logic [TOD_W-1:0]       tod1_ff, tod2_ff;
   logic [MIN_PROD_W-1:0]  prod1_ff, prod1_in;
   logic [MINS_W-1:0]      qm2_ff, qm2_in;
   logic [TOD_W-1:0]       mul2_ff, mul2_in;
   logic [TOD_W-1:0]       diff3;
   logic [6:0]             rem3;
   logic [MINS_W-1:0]      mins3_ff, mins3_in;
   logic [SEC_W-1:0]       sec3_ff, sec3_in;
   logic [HOUR_PROD_W-1:0] prod4_ff, prod4_in;
   logic [MINS_W-1:0]      mins4_ff, mins5_ff;
   logic [SEC_W-1:0]       sec4_ff, sec5_ff, sec6_ff, sec7_ff;
   logic [HOUR_W-1:0]      qh5_ff, qh5_in;
   logic [MINS_W-1:0]      mul5_ff, mul5_in;
   logic [MINS_W-1:0]      diff6;
   logic [6:0]             rem6;
   logic [HOUR_W-1:0]      hour6_ff, hour6_in, hour7_ff;
   logic [MIN_W-1:0]       min6_ff, min6_in, min7_ff;

   always_comb begin
      valid_in = {valid_ff[5:0], in_valid};
      prod1_in = MIN_PROD_W'(in_tod) * MIN_PROD_W'(MIN_RECIP);
      qm2_in   = prod1_ff[MIN_PROD_W-1 -: MINS_W];
      mul2_in  = TOD_W'(qm2_in) * TOD_W'(SECS_PER_MIN);
      diff3    = tod2_ff - mul2_ff;
      rem3     = diff3[6:0];
      if (rem3 >= 7'(SECS_PER_MIN)) begin
         mins3_in = qm2_ff + MINS_W'(1);
         sec3_in  = SEC_W'(rem3 - 7'(SECS_PER_MIN));
      end else begin
         mins3_in = qm2_ff;
         sec3_in  = SEC_W'(rem3);
      end
      prod4_in = HOUR_PROD_W'(mins3_ff) * HOUR_PROD_W'(HOUR_RECIP);
      qh5_in   = prod4_ff[HOUR_PROD_W-1 -: HOUR_W];
      mul5_in  = MINS_W'(qh5_in) * MINS_W'(MINS_PER_HOUR);
      diff6    = mins5_ff - mul5_ff;
      rem6     = diff6[6:0];
      if (rem6 >= 7'(MINS_PER_HOUR)) begin
         hour6_in = qh5_ff + HOUR_W'(1);
         min6_in  = MIN_W'(rem6 - 7'(MINS_PER_HOUR));
      end else begin
         hour6_in = qh5_ff;
         min6_in  = MIN_W'(rem6);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tod1_ff  <= in_tod;
      prod1_ff <= prod1_in;
      tod2_ff  <= tod1_ff;
      qm2_ff   <= qm2_in;
      mul2_ff  <= mul2_in;
      mins3_ff <= mins3_in;
      sec3_ff  <= sec3_in;
      prod4_ff <= prod4_in;
      mins4_ff <= mins3_ff;
      sec4_ff  <= sec3_ff;
      qh5_ff   <= qh5_in;
      mul5_ff  <= mul5_in;
      mins5_ff <= mins4_ff;
      sec5_ff  <= sec4_ff;
      hour6_ff <= hour6_in;
      min6_ff  <= min6_in;
      sec6_ff  <= sec5_ff;
      hour7_ff <= hour6_ff;
      min7_ff  <= min6_ff;
      sec7_ff  <= sec6_ff;
   end

   assign out_valid  = valid_ff[6];
   assign out_hour   = hour7_ff;
   assign out_minute = min7_ff;
   assign out_second = sec7_ff;

   `ESC_ASSERT_NEXT(hms_range_a, clock, reset, valid_ff[5], (hour7_ff < HOUR_W'(24)) && (min7_ff < MIN_W'(MINS_PER_HOUR)) && (sec7_ff < SEC_W'(SECS_PER_MIN)))

endmodule

// ===== hdl/esc_date.sv =====
`include "assert_macros.svh"

module esc_date (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [esc_pkg::DAYS_W-1:0]  in_days,
   output logic                        out_valid,
   output logic [esc_pkg::YEAR_W-1:0]  out_year,
   output logic [esc_pkg::MONTH_W-1:0] out_month,
   output logic [esc_pkg::MDAY_W-1:0]  out_mday,
   output logic [esc_pkg::WDAY_W-1:0]  out_wday
);
   import esc_pkg::*;

   logic [6:0]             valid_ff, valid_in;
   // stage 1: reciprocal products
   logic [DAYS_W-1:0]      days1_ff, days2_ff;
   logic [WEEK_W-1:0]      w1_in, w1_ff, w2_ff;
   logic [YEAR_PROD_W-1:0] py1_ff, py1_in;
   logic [WEEK_PROD_W-1:0] pw1_ff, pw1_in;
   // stage 2: quotient estimates times divisor
   logic [OFF_W-1:0]       qy2_ff, qy2_in;
   logic [WEEK_W-1:0]      muly2_ff, muly2_in;
   logic [WEEK_W-1:0]      mulw2_ff, mulw2_in;
   // stage 3: correction
   logic [WEEK_W-1:0]      ry_diff, rw_diff;
   logic [9:0]             ry;
   logic [3:0]             rw;
   logic [OFF_W-1:0]       off3_ff, off3_in;
   logic [DOY_W-1:0]       r3_ff, r3_in;
   logic [WDAY_W-1:0]      wd3_ff, wd3_in;
   // stage 4: remove leap days
   logic [9:0]             t4_ff, t4_in;
   logic [OFF_W-1:0]       off4_ff;
   logic [WDAY_W-1:0]      wd4_ff;
   // stage 5: step back a year if needed
   logic [OFF_W-1:0]       off_m1;
   logic [9:0]             back;
   logic [OFF_W-1:0]       off5_ff, off5_in;
   logic [DOY_W-1:0]       doy5_ff, doy5_in;
   logic                   leap5_ff, leap5_in;
   logic [WDAY_W-1:0]      wd5_ff;
   // stage 6: month search
   logic [MONTH_W-1:0]     month6_ff, month6_in;
   logic [OFF_W-1:0]       off6_ff;
   logic [DOY_W-1:0]       doy6_ff;
   logic                   leap6_ff;
   logic [WDAY_W-1:0]      wd6_ff;
   // stage 7: output
   logic [YEAR_W-1:0]      year7_ff, year7_in;
   logic [MONTH_W-1:0]     month7_ff;
   logic [MDAY_W-1:0]      mday7_ff, mday7_in;
   logic [WDAY_W-1:0]      wd7_ff;

   always_comb begin
      valid_in = {valid_ff[5:0], in_valid};

      w1_in  = WEEK_W'(in_days) + WEEK_W'(EPOCH_WDAY);
      py1_in = YEAR_PROD_W'(in_days) * YEAR_PROD_W'(YEAR_RECIP);
      pw1_in = WEEK_PROD_W'(w1_in) * WEEK_PROD_W'(WEEK_RECIP);

      qy2_in   = py1_ff[YEAR_PROD_W-1 -: OFF_W];
      muly2_in = WEEK_W'(qy2_in) * WEEK_W'(DAYS_PER_YEAR);
      mulw2_in = WEEK_W'(pw1_ff[WEEK_PROD_W-1:WEEK_W]) * WEEK_W'(DAYS_PER_WEEK);

      ry_diff = WEEK_W'(days2_ff) - muly2_ff;
      ry      = ry_diff[9:0];
      if (ry >= 10'(DAYS_PER_YEAR)) begin
         off3_in = qy2_ff + OFF_W'(1);
         r3_in   = DOY_W'(ry - 10'(DAYS_PER_YEAR));
      end else begin
         off3_in = qy2_ff;
         r3_in   = DOY_W'(ry);
      end
      rw_diff = w2_ff - mulw2_ff;
      rw      = rw_diff[3:0];
      if (rw >= 4'(DAYS_PER_WEEK)) begin
         wd3_in = WDAY_W'(rw - 4'(DAYS_PER_WEEK));
      end else begin
         wd3_in = WDAY_W'(rw);
      end

      t4_in = {1'b0, r3_ff} - 10'(leaps_before(off3_ff));

      off_m1 = off4_ff - OFF_W'(1);
      back   = t4_ff + 10'(DAYS_PER_YEAR) + 10'(leap_of_off(off_m1));
      if (t4_ff[9]) begin
         off5_in = off_m1;
         doy5_in = back[DOY_W-1:0];
      end else begin
         off5_in = off4_ff;
         doy5_in = t4_ff[DOY_W-1:0];
      end
      leap5_in = leap_of_off(off5_in);

      month6_in = '0;
      for (int i = 1; i < MONTHS; i++) begin
         if (doy5_ff >= cum_days(MONTH_W'(i), leap5_ff)) begin
            month6_in = month6_in + MONTH_W'(1);
         end
      end

      year7_in = YEAR_W'(EPOCH_YEAR) + YEAR_W'(off6_ff);
      mday7_in = MDAY_W'(doy6_ff - cum_days(month6_ff, leap6_ff) + DOY_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      days1_ff  <= in_days;
      w1_ff     <= w1_in;
      py1_ff    <= py1_in;
      pw1_ff    <= pw1_in;
      days2_ff  <= days1_ff;
      w2_ff     <= w1_ff;
      qy2_ff    <= qy2_in;
      muly2_ff  <= muly2_in;
      mulw2_ff  <= mulw2_in;
      off3_ff   <= off3_in;
      r3_ff     <= r3_in;
      wd3_ff    <= wd3_in;
      t4_ff     <= t4_in;
      off4_ff   <= off3_ff;
      wd4_ff    <= wd3_ff;
      off5_ff   <= off5_in;
      doy5_ff   <= doy5_in;
      leap5_ff  <= leap5_in;
      wd5_ff    <= wd4_ff;
      month6_ff <= month6_in;
      off6_ff   <= off5_ff;
      doy6_ff   <= doy5_ff;
      leap6_ff  <= leap5_ff;
      wd6_ff    <= wd5_ff;
      year7_ff  <= year7_in;
      month7_ff <= month6_ff;
      mday7_ff  <= mday7_in;
      wd7_ff    <= wd6_ff;
   end

   assign out_valid = valid_ff[6];
   assign out_year  = year7_ff;
   assign out_month = month7_ff;
   assign out_mday  = mday7_ff;
   assign out_wday  = wd7_ff;

   `ESC_ASSERT_IMPLY(doy_in_year_a, clock, reset, valid_ff[4], doy5_ff < DOY_W'(DAYS_PER_YEAR) + DOY_W'(leap5_ff))
   `ESC_ASSERT_NEXT(date_range_a, clock, reset, valid_ff[5], (month7_ff < MONTH_W'(MONTHS)) && (mday7_ff != '0) && (wd7_ff < WDAY_W'(DAYS_PER_WEEK)))

endmodule

// ===== hdl/epoch_seconds_to_calendar_top.sv =====
// Each taken request passes through the day split and then the parallel date and clock pipelines to its rsp_valid beat.
// Throughput: one request per cycle while busy is low; every one of the 10 stages takes a new beat each cycle.
// The receiver cannot stall; every accepted request yields exactly one rsp_valid beat.
// Reset (synchronous) clears all valid bits; busy is high while reset is held and drops
// at the first edge that samples reset low.
`include "assert_macros.svh"

module epoch_seconds_to_calendar_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [esc_pkg::SECS_W-1:0]  req_epoch_seconds,
   output logic                        rsp_valid,
   output logic [esc_pkg::YEAR_W-1:0]  rsp_year,
   output logic [esc_pkg::MONTH_W-1:0] rsp_month_index,
   output logic [esc_pkg::MDAY_W-1:0]  rsp_day_of_month,
   output logic [esc_pkg::HOUR_W-1:0]  rsp_hour_of_day,
   output logic [esc_pkg::MIN_W-1:0]   rsp_minute_of_hour,
   output logic [esc_pkg::SEC_W-1:0]   rsp_second_of_minute,
   output logic [esc_pkg::WDAY_W-1:0]  rsp_weekday
);
   import esc_pkg::*;

   logic              busy_ff;
   logic              accept;
   logic              split_valid;
   logic [DAYS_W-1:0] split_days;
   logic [TOD_W-1:0]  split_tod;
   logic              date_valid;
   logic              clock_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   esc_day_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_secs   (req_epoch_seconds),
      .out_valid (split_valid),
      .out_days  (split_days),
      .out_tod   (split_tod)
   );

   esc_date u_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_days   (split_days),
      .out_valid (date_valid),
      .out_year  (rsp_year),
      .out_month (rsp_month_index),
      .out_mday  (rsp_day_of_month),
      .out_wday  (rsp_weekday)
   );

   esc_clock u_clock (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (split_valid),
      .in_tod     (split_tod),
      .out_valid  (clock_valid),
      .out_hour   (rsp_hour_of_day),
      .out_minute (rsp_minute_of_hour),
      .out_second (rsp_second_of_minute)
   );

   assign rsp_valid = date_valid;

   `ESC_ASSERT_IMPLY(paths_aligned_a, clock, reset, date_valid || clock_valid, date_valid && clock_valid)

endmodule

// ===== verif/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import esc_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int PIPE_LATENCY  = 10;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_BEATS  = 250;
   localparam int MAX_REPORTS   = 10;
   localparam int DAY_SECS      = 86400;
   localparam int HOUR_SECS     = 3600;
   localparam int MINUTE_SECS   = 60;
   localparam int BASE_YEAR     = 1970;
   localparam int LAST_YEAR     = 2106;
   localparam int LAST_DAY      = 49710;
   localparam int BASE_WEEKDAY  = 4;

   localparam int MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   localparam int EDGE_OFFSETS [8] = '{-1, 0, 30, 58, 59, 60, 334, 364};
   localparam int IDLE_RATES [3] = '{24, 62, 0};

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month_index;
      logic [MDAY_W-1:0]  day_of_month;
      logic [HOUR_W-1:0]  hour_of_day;
      logic [MIN_W-1:0]   minute_of_hour;
      logic [SEC_W-1:0]   second_of_minute;
      logic [WDAY_W-1:0]  weekday;
   } calendar_type;

   typedef struct packed {
      logic [SECS_W-1:0] secs;
      logic              typed;
      calendar_type      want;
   } stim_row_type;

   localparam calendar_type NO_DATE = '0;
   localparam int DIRECTED_ROWS = 20;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      {32'd0,          1'b1, {12'd1970, 4'd0, 5'd1, 5'd0,  6'd0,  6'd0,  3'd4}},
      {32'd86399,      1'b1, {12'd1970, 4'd0, 5'd1, 5'd23, 6'd59, 6'd59, 3'd4}},
      {32'd86400,      1'b1, {12'd1970, 4'd0, 5'd2, 5'd0,  6'd0,  6'd0,  3'd5}},
      {32'hFFFFFFFF,   1'b1, {12'd2106, 4'd1, 5'd7, 5'd6,  6'd28, 6'd15, 3'd0}},
      {32'd1,          1'b0, NO_DATE},
      {32'd31449600,   1'b0, NO_DATE},   // Dec 31 1970
      {32'd31535999,   1'b0, NO_DATE},
      {32'd31536000,   1'b0, NO_DATE},
      {32'd68169600,   1'b0, NO_DATE},   // Feb 29 1972
      {32'd68256000,   1'b0, NO_DATE},
      {32'd126144000,  1'b0, NO_DATE},   // Dec 31 1973, year guess one high
      {32'd951782400,  1'b0, NO_DATE},   // Feb 29 2000
      {32'd978220800,  1'b0, NO_DATE},
      {32'd4107456000, 1'b0, NO_DATE},   // 2100 is not leap
      {32'd4107542400, 1'b0, NO_DATE},
      {32'h7FFFFFFF,   1'b0, NO_DATE},
      {32'h80000000,   1'b0, NO_DATE},
      {32'h55555555,   1'b0, NO_DATE},
      {32'hAAAAAAAA,   1'b0, NO_DATE},
      {32'hFFFFFFFE,   1'b0, NO_DATE}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [SECS_W-1:0] req_epoch_seconds = '0;
   logic              busy;
   logic              rsp_valid;
   logic [YEAR_W-1:0] rsp_year;
   logic [MONTH_W-1:0] rsp_month_index;
   logic [MDAY_W-1:0] rsp_day_of_month;
   logic [HOUR_W-1:0] rsp_hour_of_day;
   logic [MIN_W-1:0]  rsp_minute_of_hour;
   logic [SEC_W-1:0]  rsp_second_of_minute;
   logic [WDAY_W-1:0] rsp_weekday;

   calendar_type expected_dates [$];
   int        date_mismatches = 0;
   int        dates_checked = 0;
   int        leap_days_seen = 0;
   int        year_ends_seen = 0;
   int        directed_sent = 0;
   int        random_sent = 0;
   int        idle_pct = 0;
   int        stall_cycles = 0;

   epoch_seconds_to_calendar_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_epoch_seconds    (req_epoch_seconds),
      .rsp_valid            (rsp_valid),
      .rsp_year             (rsp_year),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month),
      .rsp_hour_of_day      (rsp_hour_of_day),
      .rsp_minute_of_hour   (rsp_minute_of_hour),
      .rsp_second_of_minute (rsp_second_of_minute),
      .rsp_weekday          (rsp_weekday)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int leap_days_through(input int yr);
      return yr / 4 - yr / 100 + yr / 400;
   endfunction

   function automatic bit leap_year_of(input int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // day number of Jan 1 of a year, counted from the epoch
   function automatic int new_year_day(input int yr);
      return (yr - BASE_YEAR) * 365 + leap_days_through(yr - 1)
             - leap_days_through(BASE_YEAR - 1);
   endfunction

   function automatic calendar_type predict_calendar(input logic [SECS_W-1:0] secs);
      calendar_type date;
      int unsigned  day_count;
      int unsigned  tod;
      int           yr;
      int           day_in_year;
      int           mon;
      day_count   = secs / DAY_SECS;
      tod         = secs % DAY_SECS;
      yr          = BASE_YEAR + int'(day_count / 365);
      day_in_year = int'(day_count) - new_year_day(yr);
      if (day_in_year < 0) begin
         yr          = yr - 1;
         day_in_year = day_in_year + 365 + int'(leap_year_of(yr));
      end
      mon = 0;
      while (mon < 11 &&
             day_in_year >= MONTH_DAYS[mon] + ((mon == 1 && leap_year_of(yr)) ? 1 : 0)) begin
         day_in_year = day_in_year - MONTH_DAYS[mon]
                       - ((mon == 1 && leap_year_of(yr)) ? 1 : 0);
         mon++;
      end
      date.year             = YEAR_W'(yr);
      date.month_index      = MONTH_W'(mon);
      date.day_of_month     = MDAY_W'(day_in_year + 1);
      date.hour_of_day      = HOUR_W'(tod / HOUR_SECS);
      date.minute_of_hour   = MIN_W'((tod % HOUR_SECS) / MINUTE_SECS);
      date.second_of_minute = SEC_W'(tod % MINUTE_SECS);
      date.weekday          = WDAY_W'((day_count + BASE_WEEKDAY) % 7);
      return date;
   endfunction

   // raw 32-bit values for four draws in ten, the rest aimed at day, month and year edges
   function automatic logic [SECS_W-1:0] random_epoch();
      int     kind;
      int     day;
      int     tod;
      longint stamp;
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
         0: tod = 0;
         1: tod = DAY_SECS - 1;
         default: tod = $urandom_range(0, DAY_SECS - 1);
      endcase
      if (kind < 4) begin
         return $urandom;
      end else if (kind < 6) begin
         day = $urandom_range(0, LAST_DAY);
      end else begin
         day = new_year_day($urandom_range(BASE_YEAR, LAST_YEAR));
         if ($urandom_range(0, 2) == 0) begin
            day = day + $urandom_range(0, 365);
         end else begin
            day = day + EDGE_OFFSETS[$urandom_range(0, 7)];
         end
      end
      stamp = longint'(day) * DAY_SECS + tod;
      if (stamp < 0 || stamp > longint'(32'hFFFFFFFF)) begin
         return $urandom;
      end
      return SECS_W'(stamp);
   endfunction

   task automatic send_epoch(input logic [SECS_W-1:0] secs, input logic typed,
                             input calendar_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start             <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (busy);
      expected_dates.push_back(typed ? want : predict_calendar(secs));
   endtask

   always @(posedge clock) begin
      calendar_type got;
      calendar_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_year, rsp_month_index, rsp_day_of_month, rsp_hour_of_day,
                rsp_minute_of_hour, rsp_second_of_minute, rsp_weekday};
         if (expected_dates.size() == 0) begin
            date_mismatches++;
            if (date_mismatches <= MAX_REPORTS) begin
               $display("%0t: unexpected beat %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                        got.year, got.month_index, got.day_of_month, got.hour_of_day,
                        got.minute_of_hour, got.second_of_minute, got.weekday);
            end
         end else begin
            want = expected_dates.pop_front();
            dates_checked++;
            if (want.month_index == 4'd1 && want.day_of_month == 5'd29) begin
               leap_days_seen++;
            end
            if (want.month_index == 4'd11 && want.day_of_month == 5'd31) begin
               year_ends_seen++;
            end
            if (got.year !== want.year || got.month_index !== want.month_index ||
                got.day_of_month !== want.day_of_month ||
                got.hour_of_day !== want.hour_of_day ||
                got.minute_of_hour !== want.minute_of_hour ||
                got.second_of_minute !== want.second_of_minute ||
                got.weekday !== want.weekday) begin
               date_mismatches++;
               if (date_mismatches <= MAX_REPORTS) begin
                  $display("%0t: exp %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                           want.year, want.month_index, want.day_of_month,
                           want.hour_of_day, want.minute_of_hour,
                           want.second_of_minute, want.weekday);
                  $display("%0t: got %0d-%0d-%0d %0d:%0d:%0d wd %0d", $realtime,
                           got.year, got.month_index, got.day_of_month,
                           got.hour_of_day, got.minute_of_hour,
                           got.second_of_minute, got.weekday);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d cycles without a beat", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = IDLE_RATES[0];
      foreach (DIRECTED[i]) begin
         send_epoch(DIRECTED[i].secs, DIRECTED[i].typed, DIRECTED[i].want);
         directed_sent++;
      end
      foreach (IDLE_RATES[p]) begin
         idle_pct = IDLE_RATES[p];
         repeat (RANDOM_BEATS) begin
            send_epoch(random_epoch(), 1'b0, NO_DATE);
            random_sent++;
         end
      end
      @(negedge clock);
      start <= 1'b0;

      while (expected_dates.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 5) @(posedge clock);

      $display("covered %0d directed and %0d random timestamps, sender idle 24/62/0 pct",
               directed_sent, random_sent);
      $display("%0d dates checked, %0d leap days, %0d year-end days, %0d mismatches",
               dates_checked, leap_days_seen, year_ends_seen, date_mismatches);
      if (date_mismatches == 0 && expected_dates.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
